// ===== design/heartbeat_dead_node_monitor_unit_assert.svh =====
// Assertion macros for the heartbeat dead node monitor.
// Included by the top level; defining ASSERT_OFF removes every check.
`ifndef HEARTBEAT_DEAD_NODE_MONITOR_UNIT_ASSERT_SVH
`define HEARTBEAT_DEAD_NODE_MONITOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define HDNM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define HDNM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HDNM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define HDNM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/hdnm_pkg.sv =====
// Shared types and constants of the heartbeat dead node monitor.
// No dependencies; used by the channel interfaces, the top level and the testbench.
`default_nettype none

package hdnm_pkg;

  localparam int MAX_NODES_DEF = 32;

  localparam int MISS_W = 8;
  localparam int NODE_W = 5;
  localparam int NIU_W  = 6;
  localparam int MASK_W = 32;
  localparam int ACT_W  = 3;
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [MISS_W-1:0] MISS_LIMIT_RST   = 8'd5;
  localparam logic [NODE_W-1:0] LOCAL_NODE_RST   = 5'd0;
  localparam logic [NIU_W-1:0]  NODES_IN_USE_RST = 6'd32;
  localparam logic [MASK_W-1:0] DELETED_MASK_RST = 32'd0;
  localparam logic              TRANSPORT_UP_RST = 1'b1;

  localparam logic FUNC_TRAFFIC = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_SKIPPED       = 3'd0,
    ACT_STILL_DOWN    = 3'd1,
    ACT_RECONNECTED   = 3'd2,
    ACT_ALIVE         = 3'd3,
    ACT_DECLARED_DOWN = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    REG_MISS_LIMIT   = 3'd0,
    REG_LOCAL_NODE   = 3'd1,
    REG_NODES_IN_USE = 3'd2,
    REG_DELETED_MASK = 3'd3,
    REG_TRANSPORT_UP = 3'd4
  } reg_idx_e;

endpackage

`default_nettype wire

// ===== design/hdnm_in_if.sv =====
// Input channel of the heartbeat dead node monitor: one traffic or tick beat.
// Depends on hdnm_pkg for the field widths.
`default_nettype none

interface hdnm_in_if;
  import hdnm_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [NODE_W-1:0] node_index;

  modport source (output valid, func, node_index, input ready);
  modport sink (input valid, func, node_index, output ready);
endinterface

`default_nettype wire

// ===== design/hdnm_out_if.sv =====
// Result channel of the heartbeat dead node monitor: one beat per walked node.
// Depends on hdnm_pkg for the field widths and the action type.
`default_nettype none

interface hdnm_out_if;
  import hdnm_pkg::*;

  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] peer_index;
  logic [ACT_W-1:0]  action;
  logic              keepalive_sent;
  logic              last;

  modport source (output valid, peer_index, action, keepalive_sent, last, input ready);
  modport sink (input valid, peer_index, action, keepalive_sent, last, output ready);
endinterface

`default_nettype wire

// ===== design/hdnm_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; the read data holds while no read is issued.
`default_nettype none

module hdnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/heartbeat_dead_node_monitor_unit.sv =====
// Heartbeat dead node monitor: tracks which peers are heard and declares silent ones down.
// Depends on hdnm_pkg, hdnm_in_if, hdnm_out_if, hdnm_ram and the assertion header.
//
// A traffic beat marks one node as heard. A tick beat starts a walk over the first
// min(nodes_in_use, MAX_NODES, 32) entries, one entry per cycle while the result register
// is not stalled; a stalled result register holds the walk in place. The miss count of an
// entry is read from a one-read, one-write memory into its registered read port, then
// updated and written back in the same cycle that loads the result register. Input beats
// are refused until the last entry of a walk has loaded the result register. Reset clears
// heard marks and miss count validity and sets down marks; no clearing pass is needed.
`default_nettype none

`include "heartbeat_dead_node_monitor_unit_assert.svh"

module heartbeat_dead_node_monitor_unit #(
  parameter int MAX_NODES = hdnm_pkg::MAX_NODES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hdnm_pkg::APB_AW-1:0] paddr,
  input  logic [hdnm_pkg::APB_DW-1:0] pwdata,
  output logic [hdnm_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  hdnm_in_if.sink                     in_i,
  hdnm_out_if.source                  out_o
);
  import hdnm_pkg::*;

  localparam int IW  = $clog2(MAX_NODES);
  localparam int LIM = (MAX_NODES < 32) ? MAX_NODES : 32;
  localparam int CW  = $clog2(LIM + 1);

  logic [MISS_W-1:0] miss_limit_q;
  logic [NODE_W-1:0] local_node_q;
  logic [NIU_W-1:0]  nodes_in_use_q;
  logic [MASK_W-1:0] deleted_mask_q;
  logic              transport_up_q;
  logic              cfg_we;
  reg_idx_e          reg_idx;

  logic [MAX_NODES-1:0] heard_q;
  logic [MAX_NODES-1:0] down_q;
  logic [MAX_NODES-1:0] mvalid_q;

  logic          walk_q;
  logic [CW-1:0] nxt_q;
  logic [CW-1:0] end_q;
  logic [CW-1:0] nxt_inc;
  logic [CW-1:0] tick_count;
  logic          s1_valid_q;
  logic [IW-1:0] s1_idx_q;
  logic          s1_last_q;

  logic in_fire;
  logic tick_start;
  logic trf_set;
  logic advance;
  logic rd_en;
  logic rd_last;
  logic eval_fire;

  logic [MISS_W-1:0] ram_rdata;
  logic [MISS_W-1:0] miss_cur;
  logic [MISS_W-1:0] miss_inc;
  logic [MISS_W-1:0] miss_wr;
  logic              heard_cur;
  logic              down_cur;
  logic              skip;
  logic              heard_clr;
  logic              down_set;
  logic              down_clr;
  logic              ka;
  action_e           act;

  logic              out_valid_q;
  logic [NODE_W-1:0] peer_q;
  action_e           act_q;
  logic              ka_q;
  logic              last_q;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_limit_q   <= MISS_LIMIT_RST;
      local_node_q   <= LOCAL_NODE_RST;
      nodes_in_use_q <= NODES_IN_USE_RST;
      deleted_mask_q <= DELETED_MASK_RST;
      transport_up_q <= TRANSPORT_UP_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_MISS_LIMIT:   miss_limit_q   <= pwdata[MISS_W-1:0];
        REG_LOCAL_NODE:   local_node_q   <= pwdata[NODE_W-1:0];
        REG_NODES_IN_USE: nodes_in_use_q <= pwdata[NIU_W-1:0];
        REG_DELETED_MASK: deleted_mask_q <= pwdata[MASK_W-1:0];
        REG_TRANSPORT_UP: transport_up_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MISS_LIMIT:   prdata = APB_DW'(miss_limit_q);
      REG_LOCAL_NODE:   prdata = APB_DW'(local_node_q);
      REG_NODES_IN_USE: prdata = APB_DW'(nodes_in_use_q);
      REG_DELETED_MASK: prdata = APB_DW'(deleted_mask_q);
      REG_TRANSPORT_UP: prdata = APB_DW'(transport_up_q);
      default:          prdata = '0;
    endcase
  end

  // Input side and walk sequencing.
  assign in_i.ready = !walk_q && !s1_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign tick_count = (32'(nodes_in_use_q) > LIM) ? CW'(LIM) : CW'(nodes_in_use_q);
  assign tick_start = in_fire && (in_i.func == FUNC_TICK) && (tick_count != '0);
  assign trf_set    = in_fire && (in_i.func == FUNC_TRAFFIC)
                      && (32'(in_i.node_index) < MAX_NODES);

  assign eval_fire = s1_valid_q && (!out_valid_q || out_o.ready);
  assign advance   = !s1_valid_q || eval_fire;
  assign rd_en     = walk_q && advance;
  assign nxt_inc   = nxt_q + 1'b1;
  assign rd_last   = (nxt_inc == end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q     <= 1'b0;
      nxt_q      <= '0;
      end_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_idx_q   <= '0;
      s1_last_q  <= 1'b0;
    end else begin
      if (tick_start) begin
        walk_q <= 1'b1;
        nxt_q  <= '0;
        end_q  <= tick_count;
      end else if (rd_en) begin
        nxt_q <= nxt_inc;
        if (rd_last) begin
          walk_q <= 1'b0;
        end
      end
      if (rd_en) begin
        s1_valid_q <= 1'b1;
        s1_idx_q   <= nxt_q[IW-1:0];
        s1_last_q  <= rd_last;
      end else if (eval_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  hdnm_ram #(
    .WIDTH (MISS_W),
    .DEPTH (MAX_NODES)
  ) u_miss_ram (
    .clk_i   (clk_i),
    .we_i    (eval_fire && !skip),
    .waddr_i (s1_idx_q),
    .wdata_i (miss_wr),
    .re_i    (rd_en),
    .raddr_i (nxt_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Per-entry update.
  assign heard_cur = heard_q[s1_idx_q];
  assign down_cur  = down_q[s1_idx_q];
  assign miss_cur  = mvalid_q[s1_idx_q] ? ram_rdata : '0;
  assign skip      = deleted_mask_q[5'(s1_idx_q)] || (5'(s1_idx_q) == local_node_q);
  assign miss_inc  = heard_cur ? '0
                   : ((miss_cur == '1) ? miss_cur : miss_cur + 1'b1);

  always_comb begin
    act       = ACT_SKIPPED;
    ka        = 1'b0;
    miss_wr   = miss_cur;
    heard_clr = 1'b0;
    down_set  = 1'b0;
    down_clr  = 1'b0;
    priority if (skip) begin
      act = ACT_SKIPPED;
    end else if (down_cur) begin
      if (heard_cur) begin
        down_clr = 1'b1;
        miss_wr  = '0;
        act      = ACT_RECONNECTED;
      end else begin
        act = ACT_STILL_DOWN;
      end
    end else begin
      heard_clr = 1'b1;
      ka        = transport_up_q;
      if (miss_inc >= miss_limit_q) begin
        down_set = 1'b1;
        miss_wr  = '0;
        act      = ACT_DECLARED_DOWN;
      end else begin
        miss_wr = miss_inc;
        act     = ACT_ALIVE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heard_q  <= '0;
      down_q   <= '1;
      mvalid_q <= '0;
    end else begin
      if (trf_set) begin
        heard_q[IW'(in_i.node_index)] <= 1'b1;
      end
      if (eval_fire) begin
        if (heard_clr) begin
          heard_q[s1_idx_q] <= 1'b0;
        end
        if (down_set) begin
          down_q[s1_idx_q] <= 1'b1;
        end else if (down_clr) begin
          down_q[s1_idx_q] <= 1'b0;
        end
        if (!skip) begin
          mvalid_q[s1_idx_q] <= 1'b1;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eval_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      peer_q <= 5'(s1_idx_q);
      act_q  <= act;
      ka_q   <= ka;
      last_q <= s1_last_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.peer_index     = peer_q;
  assign out_o.action         = act_q;
  assign out_o.keepalive_sent = ka_q;
  assign out_o.last           = last_q;

  `HDNM_ASSERT_IMP(a_no_accept_during_eval, clk_i, rst_ni, eval_fire, !in_fire,
                   "input beat accepted while a walk entry is evaluated")
  `HDNM_ASSERT_IMP(a_walk_starts_on_tick, clk_i, rst_ni, $rose(walk_q),
                   $past(in_fire && (in_i.func == FUNC_TICK)),
                   "walk started without an accepted tick")
  `HDNM_ASSERT_NXT(a_walk_drained_after_last, clk_i, rst_ni, eval_fire && s1_last_q,
                   !s1_valid_q && !walk_q,
                   "walk still active after its last entry")

endmodule

`default_nettype wire

// ===== dv/hdnm_walk_monitor.sv =====
`timescale 1ns / 100ps
// Scoreboard for the heartbeat dead node monitor: keeps its own node table and predicts
// the per-node reports of each tick walk. Depends on hdnm_pkg, hdnm_in_if and hdnm_out_if.
module hdnm_walk_monitor
  import hdnm_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  hdnm_in_if                in_mon_i,
  hdnm_out_if               out_mon_i,
  output int                mismatches_o,
  output int                reports_due_o,
  output int                beats_in_o,
  output int                reports_seen_o,
  output int                downs_o,
  output int                reconnects_o
);

  typedef struct packed {
    logic [NODE_W-1:0] peer;
    action_e           action;
    logic              keepalive;
    logic              last;
  } node_report_t;

  logic [MISS_W-1:0] miss_limit_q;
  logic [NODE_W-1:0] local_node_q;
  logic [NIU_W-1:0]  nodes_in_use_q;
  logic [MASK_W-1:0] deleted_q;
  logic              transport_q;

  logic              heard_q  [MAX_NODES];
  logic              down_q   [MAX_NODES];
  logic [MISS_W-1:0] misses_q [MAX_NODES];

  node_report_t pending_reports[$];

  function automatic void walk_table();
    int           span;
    node_report_t rpt;
    span = int'(nodes_in_use_q);
    if (span > MAX_NODES) span = MAX_NODES;
    if (span > 32) span = 32;
    for (int n = 0; n < span; n++) begin
      rpt.peer      = n[NODE_W-1:0];
      rpt.keepalive = 1'b0;
      rpt.last      = (n == span - 1);
      if (deleted_q[n] || n == local_node_q) begin
        rpt.action = ACT_SKIPPED;
      end else if (down_q[n]) begin
        if (heard_q[n]) begin
          down_q[n]   = 1'b0;
          misses_q[n] = '0;
          rpt.action  = ACT_RECONNECTED;
        end else begin
          rpt.action = ACT_STILL_DOWN;
        end
      end else begin
        if (heard_q[n]) begin
          misses_q[n] = '0;
        end else if (misses_q[n] != 8'hFF) begin
          misses_q[n] = misses_q[n] + 8'd1;
        end
        heard_q[n]    = 1'b0;
        rpt.keepalive = transport_q;
        if (misses_q[n] >= miss_limit_q) begin
          down_q[n]   = 1'b1;
          misses_q[n] = '0;
          rpt.action  = ACT_DECLARED_DOWN;
        end else begin
          rpt.action = ACT_ALIVE;
        end
      end
      pending_reports.push_back(rpt);
    end
  endfunction

  always @(posedge clk_i) begin
    node_report_t want;
    if (!rst_ni) begin
      miss_limit_q   = MISS_LIMIT_RST;
      local_node_q   = LOCAL_NODE_RST;
      nodes_in_use_q = NODES_IN_USE_RST;
      deleted_q      = DELETED_MASK_RST;
      transport_q    = TRANSPORT_UP_RST;
      for (int n = 0; n < MAX_NODES; n++) begin
        heard_q[n]  = 1'b0;
        down_q[n]   = 1'b1;
        misses_q[n] = '0;
      end
      pending_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[APB_AW-1:2]))
          REG_MISS_LIMIT:   miss_limit_q   = pwdata[MISS_W-1:0];
          REG_LOCAL_NODE:   local_node_q   = pwdata[NODE_W-1:0];
          REG_NODES_IN_USE: nodes_in_use_q = pwdata[NIU_W-1:0];
          REG_DELETED_MASK: deleted_q      = pwdata[MASK_W-1:0];
          REG_TRANSPORT_UP: transport_q    = pwdata[0];
          default: ;
        endcase
      end

      if (in_mon_i.valid && in_mon_i.ready) begin
        beats_in_o++;
        if (in_mon_i.func == FUNC_TICK) begin
          walk_table();
        end else if (in_mon_i.node_index < MAX_NODES) begin
          heard_q[in_mon_i.node_index] = 1'b1;
        end
      end

      if (out_mon_i.valid && out_mon_i.ready) begin
        reports_seen_o++;
        if (out_mon_i.action == ACT_DECLARED_DOWN) downs_o++;
        if (out_mon_i.action == ACT_RECONNECTED) reconnects_o++;
        if (pending_reports.size() == 0) begin
          $display("%0t: expected no report", $time);
          $display("%0t: actual   peer %0d action %0d keepalive %0b last %0b",
                   $time, out_mon_i.peer_index, out_mon_i.action, out_mon_i.keepalive_sent,
                   out_mon_i.last);
          mismatches_o++;
        end else begin
          want = pending_reports.pop_front();
          if (out_mon_i.peer_index !== want.peer || out_mon_i.action !== want.action ||
              out_mon_i.keepalive_sent !== want.keepalive || out_mon_i.last !== want.last) begin
            $display("%0t: expected peer %0d action %0d keepalive %0b last %0b", $time,
                     want.peer, want.action, want.keepalive, want.last);
            $display("%0t: actual   peer %0d action %0d keepalive %0b last %0b", $time,
                     out_mon_i.peer_index, out_mon_i.action, out_mon_i.keepalive_sent,
                     out_mon_i.last);
            mismatches_o++;
          end
        end
      end
    end
    reports_due_o = pending_reports.size();
  end

endmodule

// ===== dv/heartbeat_dead_node_monitor_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the heartbeat dead node monitor: drives traffic and tick beats and the
// register port, and gives the verdict. Depends on hdnm_pkg, both channel interfaces,
// the block itself and hdnm_walk_monitor.
module heartbeat_dead_node_monitor_unit_test;
  import hdnm_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int tx_idle_pct;
  int rx_idle_pct;
  int stall_token;
  int mismatches;
  int reports_due;
  int beats_in;
  int reports_seen;
  int downs;
  int reconnects;

  hdnm_in_if  in_bus ();
  hdnm_out_if out_bus ();

  heartbeat_dead_node_monitor_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_bus),
    .out_o   (out_bus)
  );

  hdnm_walk_monitor i_walk_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .in_mon_i       (in_bus),
    .out_mon_i      (out_bus),
    .mismatches_o   (mismatches),
    .reports_due_o  (reports_due),
    .beats_in_o     (beats_in),
    .reports_seen_o (reports_seen),
    .downs_o        (downs),
    .reconnects_o   (reconnects)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    int stall_seen;
    stall_left = 0;
    stall_seen = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_seen != stall_token) begin
        stall_seen = stall_token;
        stall_left = 300;
      end
      if (stall_left != 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_beat(input logic func, input logic [NODE_W-1:0] node);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.func       <= func;
    in_bus.node_index <= node;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (reports_due != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input int limit, input int local_idx, input int in_use,
                           input logic [31:0] mask, input logic up);
    apb_write(REG_MISS_LIMIT, limit);
    apb_write(REG_LOCAL_NODE, local_idx);
    apb_write(REG_NODES_IN_USE, in_use);
    apb_write(REG_DELETED_MASK, mask);
    apb_write(REG_TRANSPORT_UP, APB_DW'(up));
  endtask

  // Most traffic comes from the talking nodes so the others fall silent and get declared down.
  task automatic random_run(input int count, input int tick_pct, input logic [31:0] talkers);
    logic [NODE_W-1:0] node;
    for (int k = 0; k < count; k++) begin
      node = NODE_W'($urandom_range(0, 31));
      if ($urandom_range(0, 99) < tick_pct) begin
        send_beat(FUNC_TICK, node);
      end else begin
        if (talkers != 0 && $urandom_range(0, 3) != 0) begin
          while (!talkers[node]) node = NODE_W'($urandom_range(0, 31));
        end
        send_beat(FUNC_TRAFFIC, node);
      end
    end
  endtask

  initial begin : stimulus
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.func       <= FUNC_TRAFFIC;
    in_bus.node_index <= '0;
    tx_idle_pct = 33;
    rx_idle_pct = 75;
    stall_token = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(2, 0, 32, 32'h4000_0020, 1'b1);
    stall_token++;
    send_beat(FUNC_TICK, 5'd0);
    send_beat(FUNC_TRAFFIC, 5'd1);
    send_beat(FUNC_TRAFFIC, 5'd31);
    send_beat(FUNC_TRAFFIC, 5'd0);
    send_beat(FUNC_TRAFFIC, 5'd5);
    send_beat(FUNC_TRAFFIC, 5'd2);
    send_beat(FUNC_TICK, 5'd31);
    send_beat(FUNC_TICK, 5'd10);
    send_beat(FUNC_TRAFFIC, 5'd31);
    send_beat(FUNC_TICK, 5'd21);
    send_beat(FUNC_TICK, 5'd0);
    send_beat(FUNC_TICK, 5'd31);
    wait_drained();

    configure(0, 31, 32, 32'h0, 1'b0);
    send_beat(FUNC_TRAFFIC, 5'd0);
    send_beat(FUNC_TRAFFIC, 5'd7);
    send_beat(FUNC_TICK, 5'd0);
    send_beat(FUNC_TICK, 5'd0);
    wait_drained();

    configure(0, 31, 1, 32'h0, 1'b0);
    send_beat(FUNC_TRAFFIC, 5'd0);
    send_beat(FUNC_TICK, 5'd0);
    send_beat(FUNC_TICK, 5'd0);
    wait_drained();

    configure(3, $urandom_range(0, 31), 32, $urandom & $urandom & $urandom, 1'b1);
    random_run(60, 20, $urandom);
    wait_drained();
    configure(0, 31, 1, 32'h0, 1'b0);
    random_run(30, 40, 32'h1);
    wait_drained();

    tx_idle_pct = 75;
    rx_idle_pct = 33;
    configure(255, 31, 2, 32'h0, 1'b1);
    send_beat(FUNC_TRAFFIC, 5'd1);
    send_beat(FUNC_TICK, 5'd0);
    random_run(280, 98, 32'h1);
    wait_drained();
    configure(1, $urandom_range(0, 31), $urandom_range(1, 32), $urandom | $urandom, 1'b1);
    random_run(40, 25, $urandom);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure($urandom_range(0, 255), 0, 32, 32'hFFFF_FFFF, 1'b0);
    random_run(15, 40, $urandom);
    wait_drained();
    configure($urandom_range(0, 6), $urandom_range(0, 31), $urandom_range(1, 32),
              $urandom & $urandom, 1'($urandom_range(0, 1)));
    random_run(40, 20, $urandom);
    wait_drained();

    $display("Covered %0d input beats, %0d reports, %0d declared down, %0d reconnects.",
             beats_in, reports_seen, downs, reconnects);
    $display("Miss limits 0 to 255, walks of 1 to 32 nodes, all nodes deleted, transport down.");
    if (mismatches == 0 && reports_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
